// ===== hdl/slfq_pkg.sv =====
// Package for the sync/length deframer with frame queue.
// Holds the sync constants, operation codes, parser phases and step flags.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package slfq_pkg;

  localparam logic [7:0] SYNC_FIRST  = 8'h94;
  localparam logic [7:0] SYNC_SECOND = 8'hC3;

  localparam int LEN_OUT_W = 10;

  typedef enum logic [1:0] {
    FUNC_BYTE    = 2'd0,
    FUNC_READ    = 2'd1,
    FUNC_RELEASE = 2'd2,
    FUNC_CLEAR   = 2'd3
  } func_t;

  typedef enum logic [4:0] {
    PH_SYNC1  = 5'b00001,
    PH_SYNC2  = 5'b00010,
    PH_LEN_HI = 5'b00100,
    PH_LEN_LO = 5'b01000,
    PH_BODY   = 5'b10000
  } phase_t;

  // Per-request status produced by the control stage.
  typedef struct packed {
    logic rd;
    logic last;
    logic empty;
    logic done;
    logic drop;
    logic lerr;
  } step_flags_t;

endpackage

`default_nettype wire

// ===== hdl/slfq_in_if.sv =====
// Request channel of the deframer: valid/ready handshake with func and data_byte.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface slfq_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] func;
  logic [7:0] data_byte;

  modport source (output valid, func, data_byte, input ready);
  modport sink   (input valid, func, data_byte, output ready);
endinterface

`default_nettype wire

// ===== hdl/slfq_out_if.sv =====
// Result channel of the deframer: valid/ready handshake with the status fields.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface slfq_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       frame_last;
  logic       queue_empty;
  logic       frame_complete;
  logic       dropped_oldest;
  logic       length_error;
  logic [9:0] frame_length;

  modport source (output valid, out_byte, frame_last, queue_empty, frame_complete,
                  dropped_oldest, length_error, frame_length, input ready);
  modport sink   (input valid, out_byte, frame_last, queue_empty, frame_complete,
                  dropped_oldest, length_error, frame_length, output ready);
endinterface

`default_nettype wire

// ===== hdl/slfq_frame_store.sv =====
// Payload byte memory, one row of MAX_PAYLOAD bytes per queue slot.
// One write port, one registered read port. Uses slfq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module slfq_frame_store
  import slfq_pkg::*;
#(
  parameter int MAX_PAYLOAD = 512,
  parameter int QUEUE_SLOTS = 8
) (
  input  wire logic                           clk,
  input  wire logic                           we,
  input  wire logic [$clog2(QUEUE_SLOTS)-1:0] wslot,
  input  wire logic [(MAX_PAYLOAD > 1 ? $clog2(MAX_PAYLOAD) : 1)-1:0] widx,
  input  wire logic [7:0]                     wdata,
  input  wire logic                           re,
  input  wire logic [$clog2(QUEUE_SLOTS)-1:0] rslot,
  input  wire logic [(MAX_PAYLOAD > 1 ? $clog2(MAX_PAYLOAD) : 1)-1:0] ridx,
  output      logic [7:0]                     rdata
);

  logic [7:0] mem [QUEUE_SLOTS][MAX_PAYLOAD];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wslot][widx] <= wdata;
    end
    if (re) begin
      rdata <= mem[rslot][ridx];
    end
  end

endmodule

`default_nettype wire

// ===== hdl/slfq_len_store.sv =====
// Frame length memory, one entry per queue slot, registered read.
// A write to the entry being read is forwarded to the read data. Uses slfq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module slfq_len_store
  import slfq_pkg::*;
#(
  parameter int MAX_PAYLOAD = 512,
  parameter int QUEUE_SLOTS = 8
) (
  input  wire logic                               clk,
  input  wire logic                               we,
  input  wire logic [$clog2(QUEUE_SLOTS)-1:0]     waddr,
  input  wire logic [$clog2(MAX_PAYLOAD+1)-1:0]   wdata,
  input  wire logic [$clog2(QUEUE_SLOTS)-1:0]     raddr,
  output      logic [$clog2(MAX_PAYLOAD+1)-1:0]   rdata
);

  logic [$clog2(MAX_PAYLOAD+1)-1:0] mem [QUEUE_SLOTS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (we && (waddr == raddr)) begin
      rdata <= wdata;
    end else begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== hdl/slfq_ctrl.sv =====
// Control stage: sync/length parser, ring head/tail pointers and read position.
// Issues the frame store and length store accesses. Uses slfq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module slfq_ctrl
  import slfq_pkg::*;
#(
  parameter int MAX_PAYLOAD = 512,
  parameter int QUEUE_SLOTS = 8
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             step,
  input  wire logic [1:0]                       func,
  input  wire logic [7:0]                       data_byte,
  input  wire logic [$clog2(MAX_PAYLOAD+1)-1:0] tail_len,
  output      step_flags_t                      flags,
  output      logic                             st_we,
  output      logic [$clog2(QUEUE_SLOTS)-1:0]   st_wslot,
  output      logic [(MAX_PAYLOAD > 1 ? $clog2(MAX_PAYLOAD) : 1)-1:0] st_widx,
  output      logic                             st_re,
  output      logic [$clog2(QUEUE_SLOTS)-1:0]   st_rslot,
  output      logic [(MAX_PAYLOAD > 1 ? $clog2(MAX_PAYLOAD) : 1)-1:0] st_ridx,
  output      logic                             len_we,
  output      logic [$clog2(QUEUE_SLOTS)-1:0]   len_waddr,
  output      logic [$clog2(MAX_PAYLOAD+1)-1:0] len_wdata,
  output      logic [$clog2(QUEUE_SLOTS)-1:0]   tail_next
);

  localparam int SLOT_W = $clog2(QUEUE_SLOTS);
  localparam int POS_W  = $clog2(MAX_PAYLOAD + 1);
  localparam int IDX_W  = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

  phase_t            phase, phase_next;
  logic [15:0]       exp_len, exp_len_next;
  logic [POS_W-1:0]  wpos, wpos_next;
  logic [POS_W-1:0]  rpos, rpos_next;
  logic [SLOT_W-1:0] head, head_next;
  logic [SLOT_W-1:0] tail;
  logic [15:0]       len_lo;
  logic [POS_W-1:0]  wpos_inc;
  logic [POS_W-1:0]  rpos_inc;
  logic [SLOT_W-1:0] head_inc;

  function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] s);
    return (32'(s) == QUEUE_SLOTS - 1) ? '0 : s + 1'b1;
  endfunction

  assign len_lo   = {exp_len[15:8], data_byte};
  assign wpos_inc = wpos + 1'b1;
  assign rpos_inc = rpos + 1'b1;
  assign head_inc = next_slot(head);

  assign st_wslot  = head;
  assign st_widx   = wpos[IDX_W-1:0];
  assign st_rslot  = tail;
  assign st_ridx   = rpos[IDX_W-1:0];
  assign len_waddr = head;
  assign len_wdata = exp_len[POS_W-1:0];

  always_comb begin
    phase_next   = phase;
    exp_len_next = exp_len;
    wpos_next    = wpos;
    rpos_next    = rpos;
    head_next    = head;
    tail_next    = tail;
    flags        = '0;
    st_we        = 1'b0;
    st_re        = 1'b0;
    len_we       = 1'b0;
    if (step) begin
      unique case (func_t'(func))
        FUNC_BYTE: begin
          unique case (phase)
            PH_SYNC1: begin
              phase_next = (data_byte == SYNC_FIRST) ? PH_SYNC2 : PH_SYNC1;
            end
            PH_SYNC2: begin
              phase_next = (data_byte == SYNC_SECOND) ? PH_LEN_HI : PH_SYNC1;
            end
            PH_LEN_HI: begin
              exp_len_next = {data_byte, 8'h00};
              phase_next   = PH_LEN_LO;
            end
            PH_LEN_LO: begin
              exp_len_next = len_lo;
              if ((len_lo == 16'd0) || (32'(len_lo) > MAX_PAYLOAD)) begin
                flags.lerr = 1'b1;
                phase_next = PH_SYNC1;
              end else begin
                wpos_next  = '0;
                phase_next = PH_BODY;
              end
            end
            PH_BODY: begin
              st_we     = 1'b1;
              wpos_next = wpos_inc;
              if (32'(wpos_inc) >= 32'(exp_len)) begin
                // The ring keeps one slot free for the frame being received.
                if (head_inc == tail) begin
                  tail_next  = next_slot(tail);
                  rpos_next  = '0;
                  flags.drop = 1'b1;
                end
                len_we     = 1'b1;
                head_next  = head_inc;
                flags.done = 1'b1;
                phase_next = PH_SYNC1;
              end
            end
            default: begin
              phase_next = PH_SYNC1;
            end
          endcase
        end
        FUNC_READ: begin
          if (head != tail) begin
            if (32'(rpos) < 32'(tail_len)) begin
              st_re     = 1'b1;
              flags.rd  = 1'b1;
              rpos_next = rpos_inc;
              if (32'(rpos_inc) >= 32'(tail_len)) begin
                flags.last = 1'b1;
                tail_next  = next_slot(tail);
                rpos_next  = '0;
              end
            end else begin
              tail_next = next_slot(tail);
              rpos_next = '0;
            end
          end
        end
        FUNC_RELEASE: begin
          if (head != tail) begin
            tail_next = next_slot(tail);
          end
          rpos_next = '0;
        end
        FUNC_CLEAR: begin
          phase_next   = PH_SYNC1;
          exp_len_next = '0;
          wpos_next    = '0;
          rpos_next    = '0;
          head_next    = '0;
          tail_next    = '0;
        end
      endcase
    end
    flags.empty = (head_next == tail_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase   <= PH_SYNC1;
      exp_len <= '0;
      wpos    <= '0;
      rpos    <= '0;
      head    <= '0;
      tail    <= '0;
    end else begin
      phase   <= phase_next;
      exp_len <= exp_len_next;
      wpos    <= wpos_next;
      rpos    <= rpos_next;
      head    <= head_next;
      tail    <= tail_next;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/sync_length_deframer_with_frame_queue_top.sv =====
// Serial byte deframer: hunts for the sync pair 0x94 0xC3, takes a big-endian
// 16-bit length and stores that many payload bytes as one frame in a ring of
// QUEUE_SLOTS slots, of which QUEUE_SLOTS-1 can hold queued frames; completing
// a frame into a full ring drops the oldest one. Requests (serial byte, read,
// release, clear) are taken one per clock, back to back, and each gives exactly
// one registered result, which carries the registered read of the payload
// byte memory; a stalled result holds the request channel until it is taken.
// Depends on slfq_pkg, slfq_in_if, slfq_out_if, slfq_ctrl and the two stores.
`timescale 1ns / 1ps
`default_nettype none

module sync_length_deframer_with_frame_queue_top
  import slfq_pkg::*;
#(
  parameter int MAX_PAYLOAD = 512,
  parameter int QUEUE_SLOTS = 8
) (
  input  wire logic   clk,
  input  wire logic   rst,
  slfq_in_if.sink     req,
  slfq_out_if.source  rsp
);

  localparam int SLOT_W = $clog2(QUEUE_SLOTS);
  localparam int POS_W  = $clog2(MAX_PAYLOAD + 1);
  localparam int IDX_W  = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

  logic              step;
  step_flags_t       flags;
  step_flags_t       flags_q;
  logic              res_valid;
  logic              st_we;
  logic [SLOT_W-1:0] st_wslot;
  logic [IDX_W-1:0]  st_widx;
  logic              st_re;
  logic [SLOT_W-1:0] st_rslot;
  logic [IDX_W-1:0]  st_ridx;
  logic [7:0]        st_rdata;
  logic              len_we;
  logic [SLOT_W-1:0] len_waddr;
  logic [POS_W-1:0]  len_wdata;
  logic [SLOT_W-1:0] tail_next;
  logic [POS_W-1:0]  tail_len;

  assign req.ready = !res_valid || rsp.ready;
  assign step      = req.valid && req.ready;

  slfq_ctrl #(
    .MAX_PAYLOAD (MAX_PAYLOAD),
    .QUEUE_SLOTS (QUEUE_SLOTS)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .func      (req.func),
    .data_byte (req.data_byte),
    .tail_len  (tail_len),
    .flags     (flags),
    .st_we     (st_we),
    .st_wslot  (st_wslot),
    .st_widx   (st_widx),
    .st_re     (st_re),
    .st_rslot  (st_rslot),
    .st_ridx   (st_ridx),
    .len_we    (len_we),
    .len_waddr (len_waddr),
    .len_wdata (len_wdata),
    .tail_next (tail_next)
  );

  slfq_frame_store #(
    .MAX_PAYLOAD (MAX_PAYLOAD),
    .QUEUE_SLOTS (QUEUE_SLOTS)
  ) u_frame_store (
    .clk   (clk),
    .we    (st_we),
    .wslot (st_wslot),
    .widx  (st_widx),
    .wdata (req.data_byte),
    .re    (st_re),
    .rslot (st_rslot),
    .ridx  (st_ridx),
    .rdata (st_rdata)
  );

  // Read every cycle at the next tail, so the read data always holds the
  // length of the oldest queued frame.
  slfq_len_store #(
    .MAX_PAYLOAD (MAX_PAYLOAD),
    .QUEUE_SLOTS (QUEUE_SLOTS)
  ) u_len_store (
    .clk   (clk),
    .we    (len_we),
    .waddr (len_waddr),
    .wdata (len_wdata),
    .raddr (tail_next),
    .rdata (tail_len)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (req.ready) begin
      res_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      flags_q <= flags;
    end
  end

  assign rsp.valid          = res_valid;
  assign rsp.out_byte       = flags_q.rd ? st_rdata : 8'h00;
  assign rsp.frame_last     = flags_q.last;
  assign rsp.queue_empty    = flags_q.empty;
  assign rsp.frame_complete = flags_q.done;
  assign rsp.dropped_oldest = flags_q.drop;
  assign rsp.length_error   = flags_q.lerr;
  assign rsp.frame_length   = flags_q.empty ? '0 : LEN_OUT_W'(tail_len);

  a_reset_clears_result: assert property (@(posedge clk)
    $past(rst) |-> !rsp.valid)
    else $error("result valid right after reset");

  a_stall_holds_result: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && !rsp.ready |=> rsp.valid)
    else $error("stalled result was lost");

  a_drop_needs_complete: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.dropped_oldest |-> rsp.frame_complete && !rsp.queue_empty)
    else $error("oldest frame dropped without a completed frame");

  a_last_not_empty_len: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.queue_empty |-> rsp.frame_length == '0)
    else $error("frame length reported on an empty queue");

  a_single_event: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> !(rsp.frame_complete && (rsp.length_error || rsp.frame_last)))
    else $error("parser and reader events in one result");

endmodule

`default_nettype wire
